// ===== sv/chs_pkg.sv =====
// Shared types and constants for the chained hash set.
// Used by the channel interfaces and every module of the block; no dependencies.
package chs_pkg;

    localparam int BUCKETS  = 16;
    localparam int SLOTS    = 8;
    localparam int KEY_W    = 31;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int FILL_W   = $clog2(SLOTS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef enum logic
    {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef logic [SLOTS-1:0][KEY_W-1:0] row_t;

    // one classified item waiting for the back end
    typedef struct packed
    {
        cmd_t                cmd;
        logic [KEY_W-1:0]    key;
        logic [BUCKET_W-1:0] bucket;
    } q_entry_t;

    typedef struct packed
    {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

endpackage

// ===== sv/chs_in_if.sv =====
// Request channel of the chained hash set: command and key.
// Depends on chs_pkg for the key width.
interface chs_in_if;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [chs_pkg::KEY_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

// ===== sv/chs_out_if.sv =====
// Response channel of the chained hash set: status and matching key.
// Depends on chs_pkg for the key width.
interface chs_out_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [chs_pkg::KEY_W-1:0] found_key;

    modport source (output valid, output status, output found_key, input ready);
    modport sink   (input valid, input status, input found_key, output ready);
endinterface

// ===== sv/chs_front.sv =====
// Front end: accepts request items, computes the bucket and queues them.
// Depends on chs_pkg and chs_in_if.
module chs_front
(
    input  logic              clk,
    input  logic              rst_n,
    chs_in_if.sink            req,
    output chs_pkg::q_head_t  head,
    input  logic              pop
);

    chs_pkg::q_entry_t                 queue_reg [chs_pkg::QUEUE_DEPTH];
    logic [chs_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [chs_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [chs_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [chs_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [chs_pkg::QCNT_W-1:0]        count_reg;
    logic [chs_pkg::QCNT_W-1:0]        count_next;
    logic                              push;
    logic                              do_pop;
    chs_pkg::q_entry_t                 new_entry;

    assign req.ready = (count_reg != chs_pkg::QCNT_W'(chs_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (count_reg != '0);

    always_comb
    begin
        new_entry.cmd    = chs_pkg::cmd_t'(req.cmd);
        new_entry.key    = req.key;
        new_entry.bucket = chs_pkg::BUCKET_W'(req.key % chs_pkg::BUCKETS);
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = queue_reg[rd_ptr_reg];

    queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= chs_pkg::QCNT_W'(chs_pkg::QUEUE_DEPTH))
        else $error("item queue count beyond depth");

    queue_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("item queue count lost a push");

    queue_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !push) |=> (count_reg == '0))
        else $error("item queue count moved while empty");

endmodule

// ===== sv/chs_back.sv =====
// Back end: reads a bucket row, compares and shifts it, writes it back and
// registers the response. Depends on chs_pkg and chs_out_if.
module chs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  chs_pkg::q_head_t  head,
    output logic              pop,
    chs_out_if.source         rsp
);

    chs_pkg::row_t                row_mem [chs_pkg::BUCKETS];
    chs_pkg::row_t                row_q;
    logic [chs_pkg::FILL_W-1:0]   fill_reg [chs_pkg::BUCKETS];
    chs_pkg::back_state_t         state_reg;
    chs_pkg::back_state_t         state_next;
    chs_pkg::q_entry_t            cur_reg;
    logic [chs_pkg::FILL_W-1:0]   fill_cur_reg;
    logic                         out_valid_reg;
    chs_pkg::status_t             status_reg;
    logic [chs_pkg::KEY_W-1:0]    found_key_reg;

    logic                         load_out;
    logic                         wr_en;
    logic [chs_pkg::SLOTS-1:0]    lt_vec;
    logic [chs_pkg::SLOTS-1:0]    eq_vec;
    logic [chs_pkg::FILL_W-1:0]   ins_pos;
    logic                         is_full;
    chs_pkg::row_t                new_row;
    chs_pkg::status_t             status_new;
    logic [chs_pkg::KEY_W-1:0]    found_key_new;

    // compare the stored row against the key; only filled slots take part
    always_comb
    begin
        for (int i = 0; i < chs_pkg::SLOTS; i++)
        begin
            lt_vec[i] = (chs_pkg::FILL_W'(i) < fill_cur_reg) && (row_q[i] < cur_reg.key);
            eq_vec[i] = (chs_pkg::FILL_W'(i) < fill_cur_reg) && (row_q[i] == cur_reg.key);
        end
        // sorted row: smaller keys form a prefix, so the count is the slot
        ins_pos = chs_pkg::FILL_W'($countones(lt_vec));
        is_full = (fill_cur_reg >= chs_pkg::FILL_W'(chs_pkg::SLOTS));
        new_row[0] = (ins_pos == '0) ? cur_reg.key : row_q[0];
        for (int i = 1; i < chs_pkg::SLOTS; i++)
        begin
            if (chs_pkg::FILL_W'(i) < ins_pos)
            begin
                new_row[i] = row_q[i];
            end
            else if (chs_pkg::FILL_W'(i) == ins_pos)
            begin
                new_row[i] = cur_reg.key;
            end
            else
            begin
                new_row[i] = row_q[i-1];
            end
        end
    end

    always_comb
    begin
        found_key_new = '0;
        if (cur_reg.cmd == chs_pkg::CMD_INSERT)
        begin
            status_new = is_full ? chs_pkg::ST_FULL : chs_pkg::ST_INSERTED;
        end
        else if (eq_vec != '0)
        begin
            status_new    = chs_pkg::ST_FOUND;
            found_key_new = cur_reg.key;
        end
        else
        begin
            status_new = chs_pkg::ST_MISSING;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            chs_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    state_next = chs_pkg::BK_EXEC;
                end
            end
            chs_pkg::BK_EXEC:
            begin
                // hold here while the previous response is still unread
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    wr_en      = (cur_reg.cmd == chs_pkg::CMD_INSERT) && !is_full;
                    state_next = chs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = chs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chs_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < chs_pkg::BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else if (wr_en)
        begin
            fill_reg[cur_reg.bucket] <= fill_cur_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            row_q <= row_mem[head.entry.bucket];
        end
        if (wr_en)
        begin
            row_mem[cur_reg.bucket] <= new_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg      <= head.entry;
            fill_cur_reg <= fill_reg[head.entry.bucket];
        end
        if (load_out)
        begin
            status_reg    <= status_new;
            found_key_reg <= found_key_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.found_key = found_key_reg;

    fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chs_pkg::BK_EXEC) |-> (fill_cur_reg <= chs_pkg::FILL_W'(chs_pkg::SLOTS)))
        else $error("bucket fill beyond slot count");

    key_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != chs_pkg::ST_FOUND) |-> (rsp.found_key == '0))
        else $error("found_key set on a non-found response");

    exec_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chs_pkg::BK_EXEC && (!out_valid_reg || rsp.ready))
        |=> (out_valid_reg && state_reg == chs_pkg::BK_IDLE))
        else $error("executed item did not reach the response register");

    no_pop_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chs_pkg::BK_EXEC) |-> !pop)
        else $error("queue popped while an item is in execution");

endmodule

// ===== sv/chained_hash_set_unit.sv =====
// Chained hash set: sorted fixed-depth buckets of 31-bit keys.
// Use: send items on req (cmd 0 inserts key, cmd 1 searches for it) with
// valid/ready; each item yields exactly one response on rsp (status,
// found_key), in order. A key's bucket is its low bucket-index bits.
// Each bucket holds up to SLOTS keys in ascending order, duplicates allowed;
// an insert into a full bucket changes nothing and answers full.
// An item accepted into an empty block passes through the queue, the row
// read, then the compare/shift/write into the response register. The back
// end takes one item at a time from the bucket-row memory: a row read,
// then the compare/shift and write-back; it takes the next item only once
// the response register has taken this one.
// A two-entry queue in front keeps req ready while the back end works.
// Reset: all bucket counts clear at once; key storage needs no clearing,
// so items are taken from the first cycle after reset.
// Receiver stall: the response register holds, the back end waits with
// its item, the queue fills and then req.ready drops.
// Depends on chs_pkg, chs_in_if, chs_out_if, chs_front and chs_back.
module chained_hash_set_unit
(
    input  logic       clk,
    input  logic       rst_n,
    chs_in_if.sink     req,
    chs_out_if.source  rsp
);

    chs_pkg::q_head_t head;
    logic             pop;

    chs_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    chs_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
